// File: design/nearest_texton_label_assert.svh
// Assertion macros shared by the checker of the texton labeler.
`ifndef NEAREST_TEXTON_LABEL_ASSERT_SVH
`define NEAREST_TEXTON_LABEL_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NTL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NTL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ntl_pkg.sv
// Shared constants, payload and chain types of the texton labeler.
package ntl_pkg;

    localparam int NUM_CODEWORDS  = 32;
    localparam int NUM_CHANNELS   = 2;
    localparam int PATCH_ELEMENTS = 25;

    localparam int CW_W      = (NUM_CODEWORDS > 1) ? $clog2(NUM_CODEWORDS) : 1;
    localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int MEM_DEPTH = NUM_CHANNELS * PATCH_ELEMENTS;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int ACC_W     = 32;
    localparam int SQ_W      = 25;
    localparam int APB_AW    = 2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    localparam logic [ACC_W-1:0] ACC_MAX = '1;

    typedef struct packed {
        logic        cmd;
        logic [5:0]  code_index;
        logic [4:0]  elem_index;
        logic [11:0] code_value;
        logic [7:0]  pixel;
        logic        channel;
        logic        last_pixel;
    } ntl_in_t;

    typedef struct packed {
        logic [5:0]  texton_label;
        logic [31:0] best_dist_sq;
        logic        matched;
    } ntl_out_t;

    // Decoded transaction as it walks down the cell row.
    typedef struct packed {
        logic              valid;
        logic              wr;
        logic              add;
        logic              last;
        logic [CH_W-1:0]   chan;
        logic [CW_W-1:0]   entry;
        logic [MEM_AW-1:0] addr;
        logic [11:0]       code_value;
        logic [7:0]        pixel;
    } ntl_tok_t;

    // Running minimum handed from cell to cell with the last pixel.
    typedef struct packed {
        logic [ACC_W-1:0] best;
        logic [CW_W-1:0]  idx;
    } ntl_srch_t;

endpackage

// File: design/ntl_cell.sv
// One codeword cell: codeword storage, distance accumulator, minimum step.
module ntl_cell
    import ntl_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic [CW_W-1:0]  cell_id,
    input  ntl_tok_t         tok_in,
    input  ntl_srch_t        srch_in,
    output ntl_tok_t         tok_out,
    output ntl_srch_t        srch_out
);

    logic [11:0]      mem [MEM_DEPTH];
    logic [11:0]      rd_reg;
    ntl_tok_t         tok_reg;
    ntl_srch_t        srch_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;

    logic [11:0]        px_q;
    logic signed [12:0] diff;
    logic signed [25:0] prod;
    logic [SQ_W-1:0]    sq;
    logic [ACC_W:0]     sum;
    logic [ACC_W-1:0]   acc_upd;
    logic               take_own;

    // Codeword store, read with the transaction entering this cell.
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (tok_in.valid && tok_in.wr && tok_in.entry == cell_id) begin
                mem[tok_in.addr] <= tok_in.code_value;
            end
            rd_reg <= mem[tok_in.addr];
        end
    end

    always_comb begin
        px_q     = {tok_reg.pixel, 4'b0000};
        diff     = $signed({1'b0, px_q}) - $signed({1'b0, rd_reg});
        prod     = diff * diff;
        sq       = prod[SQ_W-1:0];
        sum      = {1'b0, acc_reg} + {{(ACC_W + 1 - SQ_W){1'b0}}, sq};
        acc_upd  = acc_reg;
        if (tok_reg.valid && tok_reg.add) begin
            acc_upd = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
        end
        // The first cell has no predecessor; ties keep the lower index.
        take_own = (cell_id == '0) || (acc_upd < srch_reg.best);
        srch_out.best = take_own ? acc_upd : srch_reg.best;
        srch_out.idx  = take_own ? cell_id : srch_reg.idx;

        acc_next = acc_reg;
        if (tok_reg.valid) begin
            acc_next = tok_reg.last ? '0 : acc_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
            acc_reg       <= '0;
        end else if (adv) begin
            tok_reg.valid <= tok_in.valid;
            acc_reg       <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tok_reg.wr         <= tok_in.wr;
            tok_reg.add        <= tok_in.add;
            tok_reg.last       <= tok_in.last;
            tok_reg.chan       <= tok_in.chan;
            tok_reg.entry      <= tok_in.entry;
            tok_reg.addr       <= tok_in.addr;
            tok_reg.code_value <= tok_in.code_value;
            tok_reg.pixel      <= tok_in.pixel;
            srch_reg           <= srch_in;
        end
    end

    assign tok_out = tok_reg;

endmodule

// File: design/nearest_texton_label.sv
// Texton labeler top level: input decode, codeword cell row, result and limit registers.
//
// Input channel s_valid/s_ready/s_data carries codebook writes (cmd = write)
// and patch pixels (cmd = pixel). Result channel m_valid/m_ready/m_data gives
// one result per pixel flagged last_pixel: the nearest codeword label of the
// pixel's channel, its squared distance and whether it beat the limit.
// The limit is a 32-bit register at APB address 0, reset to all ones.
//
// Each transaction walks a row of one cell per codeword, moving on one cell
// each time the row advances; every cell adds its squared difference as the
// pixel passes and the last pixel carries the running minimum along the row.
// The result is registered after the last cell. The block accepts one
// transaction every cycle, writes included, while no result waits on m_ready.
//
// Reset clears the accumulators and the valid flags of the row and the
// result register; the codebook holds garbage until written. While a result
// waits on m_ready the whole row holds and s_ready is low.
module nearest_texton_label
    import ntl_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ntl_in_t           s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ntl_out_t          m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [ACC_W-1:0] limit_reg;
    logic             adv;
    logic             m_valid_reg;
    ntl_out_t         m_data_reg;
    ntl_out_t         res;
    ntl_tok_t         tok_in;
    ntl_tok_t         tail_tok;
    ntl_srch_t        tail_srch;
    ntl_tok_t         tok_chain  [NUM_CODEWORDS+1];
    ntl_srch_t        srch_chain [NUM_CODEWORDS+1];

    logic              is_pix;
    logic              chan_ok;
    logic              elem_ok;
    logic              wr_hit;
    logic [CW_W-1:0]   wr_entry;
    logic [MEM_AW-1:0] wr_addr;

    // Single register: any address inside the window hits it.
    assign pready = 1'b1;
    assign prdata = limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= ACC_MAX;
        end else if (psel && penable && pwrite) begin
            limit_reg <= pwdata;
        end
    end

    // Advance the row whenever the result slot is free or being drained.
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    always_comb begin
        is_pix   = (s_data.cmd == CMD_PIXEL);
        chan_ok  = int'(s_data.channel) < NUM_CHANNELS;
        elem_ok  = int'(s_data.elem_index) < PATCH_ELEMENTS;
        wr_hit   = 1'b0;
        wr_entry = '0;
        wr_addr  = '0;
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            if (int'(s_data.code_index) >= ch * NUM_CODEWORDS &&
                int'(s_data.code_index) < (ch + 1) * NUM_CODEWORDS) begin
                wr_hit   = 1'b1;
                wr_entry = CW_W'(int'(s_data.code_index) - ch * NUM_CODEWORDS);
                wr_addr  = MEM_AW'(ch * PATCH_ELEMENTS + int'(s_data.elem_index));
            end
        end

        // Drop out-of-range writes and pixels of a missing channel here.
        tok_in.valid      = s_valid && (is_pix ? chan_ok : (wr_hit && elem_ok));
        tok_in.wr         = !is_pix;
        tok_in.add        = is_pix && elem_ok;
        tok_in.last       = is_pix && s_data.last_pixel;
        tok_in.chan       = CH_W'(s_data.channel);
        tok_in.entry      = wr_entry;
        tok_in.addr       = is_pix ?
                            MEM_AW'(int'(s_data.channel) * PATCH_ELEMENTS +
                                    int'(s_data.elem_index)) :
                            wr_addr;
        tok_in.code_value = s_data.code_value;
        tok_in.pixel      = s_data.pixel;
    end

    assign tok_chain[0]  = tok_in;
    assign srch_chain[0] = '0;

    for (genvar k = 0; k < NUM_CODEWORDS; k++) begin : g_cell
        ntl_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .cell_id  (CW_W'(k)),
            .tok_in   (tok_chain[k]),
            .srch_in  (srch_chain[k]),
            .tok_out  (tok_chain[k+1]),
            .srch_out (srch_chain[k+1])
        );
    end

    assign tail_tok  = tok_chain[NUM_CODEWORDS];
    assign tail_srch = srch_chain[NUM_CODEWORDS];

    always_comb begin
        res.best_dist_sq = tail_srch.best;
        res.matched      = tail_srch.best < limit_reg;
        res.texton_label = res.matched ?
                           6'(int'(tail_tok.chan) * NUM_CODEWORDS + int'(tail_srch.idx)) :
                           6'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= tail_tok.valid && tail_tok.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && tail_tok.valid && tail_tok.last) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: design/ntl_checker.sv
// Port-level checker for the texton labeler, bound to the top level.
`include "nearest_texton_label_assert.svh"

module ntl_checker
    import ntl_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input ntl_out_t          m_data,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [31:0]       pwdata,
    input logic [31:0]       prdata,
    input logic              pready
);

    `NTL_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result dropped or changed while stalled")
    `NTL_ASSERT_SAME(a_stall_blocks_input, m_valid && !m_ready, !s_ready, "input accepted while result stalled")
    `NTL_ASSERT_SAME(a_nomatch_label, m_valid && !m_data.matched, m_data.texton_label == 6'd0, "label nonzero without a match")
    `NTL_ASSERT_NEXT(a_limit_readback, psel && penable && pwrite && pready, prdata == $past(pwdata), "limit register does not read back")

endmodule

bind nearest_texton_label ntl_checker u_ntl_checker (.*);

// File: tb/sv/nearest_texton_label_test.sv
// Self-checking testbench for the nearest-codeword texton labeler.
`timescale 1ns / 100ps

module nearest_texton_label_test;
    import ntl_pkg::*;

    localparam int TOTAL_CODES   = NUM_CHANNELS * NUM_CODEWORDS;
    localparam int ROW_LATENCY   = NUM_CODEWORDS + 1;
    localparam int SETTLE_CYCLES = ROW_LATENCY + 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 320;
    localparam int NUM_PHASES    = 8;
    localparam int MIN_LABELS    = 8;
    localparam int SAT_PIXELS    = 260;
    // Random pixels stay on these loaded leading elements or on stray positions.
    localparam int FILL_ELEMS    = 4;

    localparam logic [APB_AW-1:0] REG_DIST_LIMIT = '0;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    ntl_in_t           s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    ntl_out_t          m_data;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    nearest_texton_label u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the codebook, the per-codeword distance sums and the limit.
    logic [11:0] code_store [TOTAL_CODES][PATCH_ELEMENTS];
    logic [31:0] dist_sum [NUM_CODEWORDS] = '{default: '0};
    logic [31:0] limit_sq = 32'hFFFF_FFFF;

    ntl_in_t  pending_q [$];
    ntl_out_t label_q [$];
    ntl_out_t want_label;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int apb_mismatches = 0;
    int quiet_cycles   = 0;

    function automatic void absorb_transaction(input ntl_in_t item);
        int px, cw, diff, base, best_k, k;
        longint unsigned total;
        logic [31:0] best;
        ntl_out_t res;
        if (item.cmd == CMD_WRITE) begin
            if (item.code_index < TOTAL_CODES && item.elem_index < PATCH_ELEMENTS)
                code_store[item.code_index][item.elem_index] = item.code_value;
            return;
        end
        if (item.channel >= NUM_CHANNELS)
            return;
        base = item.channel * NUM_CODEWORDS;
        if (item.elem_index < PATCH_ELEMENTS) begin
            px = item.pixel * 16;
            for (k = 0; k < NUM_CODEWORDS; k++) begin
                cw = code_store[base + k][item.elem_index];
                diff = px - cw;
                total = longint'(dist_sum[k]) + longint'(diff * diff);
                dist_sum[k] = (total > 64'hFFFF_FFFF) ? ACC_MAX : total[31:0];
            end
        end
        if (!item.last_pixel)
            return;
        best = dist_sum[0];
        best_k = 0;
        for (k = 1; k < NUM_CODEWORDS; k++) begin
            if (dist_sum[k] < best) begin
                best = dist_sum[k];
                best_k = k;
            end
        end
        res.best_dist_sq = best;
        res.matched      = (best < limit_sq);
        res.texton_label = res.matched ? 6'(base + best_k) : '0;
        label_q.push_back(res);
        for (k = 0; k < NUM_CODEWORDS; k++)
            dist_sum[k] = '0;
    endfunction

    function automatic void compare_field(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // Driver: hold valid and payload until the transaction is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || s_ready) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_data  <= pending_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predict on input transactions, check result transactions.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                absorb_transaction(s_data);
            if (m_valid && m_ready) begin
                if (label_q.size() == 0) begin
                    $display("%0t: result expected none got label %0d dist %0d matched %0b",
                             $time, m_data.texton_label, m_data.best_dist_sq, m_data.matched);
                    mismatches++;
                end else begin
                    want_label = label_q.pop_front();
                    compare_field("texton_label", want_label.texton_label, m_data.texton_label);
                    compare_field("best_dist_sq", want_label.best_dist_sq, m_data.best_dist_sq);
                    compare_field("matched", want_label.matched, m_data.matched);
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic void push_write(input int ci, input int e, input logic [11:0] value);
        logic [63:0] noise;
        ntl_in_t item;
        noise = {$urandom, $urandom};
        item = noise[$bits(ntl_in_t)-1:0];
        item.cmd        = CMD_WRITE;
        item.code_index = 6'(ci);
        item.elem_index = 5'(e);
        item.code_value = value;
        pending_q.push_back(item);
    endfunction

    function automatic void push_pixel(input int ch, input int e, input logic [7:0] pix,
                                       input logic last);
        logic [63:0] noise;
        ntl_in_t item;
        noise = {$urandom, $urandom};
        item = noise[$bits(ntl_in_t)-1:0];
        item.cmd        = CMD_PIXEL;
        item.channel    = ch[0];
        item.elem_index = 5'(e);
        item.pixel      = pix;
        item.last_pixel = last;
        pending_q.push_back(item);
    endfunction

    // Bias toward multiples of 16 and the extremes so exact hits and ties occur.
    function automatic logic [11:0] pick_code_value();
        case ($urandom_range(3))
            0: return 12'($urandom_range(255) * 16);
            1: return $urandom_range(1) ? 12'hFFF : 12'h000;
            default: return 12'($urandom_range(4095));
        endcase
    endfunction

    // Half the time track one target codeword so that patches land close to it.
    function automatic logic [7:0] pick_pixel(input int ch, input int k, input int e);
        int v;
        case ($urandom_range(3))
            0, 1: begin
                v = code_store[ch * NUM_CODEWORDS + k][e] / 16 + $urandom_range(1);
                return (v > 255) ? 8'hFF : 8'(v);
            end
            2: return $urandom_range(1) ? 8'hFF : 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic apply_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct  = 75;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 75;
            end
            default: begin
                send_idle_pct  = 26;
                recv_stall_pct = 26;
            end
        endcase
    endtask

    task automatic limit_transfer(input logic is_write, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= REG_DIST_LIMIT;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (!is_write && prdata !== value) begin
            $display("%0t: distance limit readback expected %0h got %0h", $time, value, prdata);
            apb_mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (is_write)
            limit_sq = value;
        @(negedge aclk);
    endtask

    task automatic set_limit(input logic [31:0] value);
        limit_transfer(1'b1, value);
        limit_transfer(1'b0, value);
    endtask

    // Wait for the queues to empty, then let in-flight writes leave the row.
    task automatic drain();
        while (pending_q.size() != 0 || s_valid || label_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic queue_random_phase(input int quota);
        int taken, finishes, kind, ch, k, len, e, i;
        taken = 0;
        finishes = 0;
        while (taken < quota || finishes < MIN_LABELS) begin
            kind = $urandom_range(9);
            ch = $urandom_range(NUM_CHANNELS - 1);
            k = $urandom_range(NUM_CODEWORDS - 1);
            if (kind <= 3) begin
                // patch over the loaded elements, in order
                for (e = 0; e < FILL_ELEMS; e++)
                    push_pixel(ch, e, pick_pixel(ch, k, e), e == FILL_ELEMS - 1);
                taken += FILL_ELEMS;
                finishes++;
            end else if (kind <= 6) begin
                // short patch, repeats allowed
                len = $urandom_range(6, 1);
                for (i = 0; i < len; i++) begin
                    e = $urandom_range(FILL_ELEMS - 1);
                    push_pixel(ch, e, pick_pixel(ch, k, e), i == len - 1);
                end
                taken += len;
                finishes++;
            end else if (kind == 7) begin
                // mixed channels and stray element positions
                len = $urandom_range(8, 2);
                for (i = 0; i < len; i++) begin
                    ch = $urandom_range(NUM_CHANNELS - 1);
                    e = $urandom_range(31);
                    if (e < PATCH_ELEMENTS) begin
                        e = e % FILL_ELEMS;
                        push_pixel(ch, e, pick_pixel(ch, k, e), i == len - 1);
                    end else begin
                        push_pixel(ch, e, 8'($urandom), i == len - 1);
                    end
                end
                taken += len;
                finishes++;
            end else begin
                len = $urandom_range(4, 1);
                for (i = 0; i < len; i++) begin
                    e = $urandom_range(31);
                    push_write($urandom_range(TOTAL_CODES - 1), e, pick_code_value());
                    if (e < PATCH_ELEMENTS)
                        taken++;
                end
            end
        end
    endtask

    initial begin
        int ci, e, i, p;
        logic [31:0] lim;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        limit_transfer(1'b0, 32'hFFFF_FFFF);

        // Load the leading elements of every codeword before any pixel reads them.
        apply_idle(IDLE_NONE);
        for (ci = 0; ci < TOTAL_CODES; ci++) begin
            for (e = 0; e < FILL_ELEMS; e++)
                push_write(ci, e, pick_code_value());
            push_write(ci, $urandom_range(31, PATCH_ELEMENTS), pick_code_value());
        end
        drain();

        // Exact hit with a tie at a higher index.
        push_write(3, 0, 12'h000);
        push_write(10, 0, 12'h000);
        push_pixel(0, 0, 8'h00, 1'b1);
        // Top codeword, brightest pixel; the stray write must not land.
        push_write(TOTAL_CODES - 1, FILL_ELEMS - 1, 12'hFFF);
        push_pixel(1, FILL_ELEMS - 1, 8'hFF, 1'b1);
        push_write(TOTAL_CODES - 1, 31, 12'h000);
        push_write(5, 27, 12'hFFF);
        push_pixel(1, FILL_ELEMS - 1, 8'hFF, 1'b1);
        // Stray positions add nothing but a last one still reports.
        push_pixel(0, 30, 8'h00, 1'b1);
        push_pixel(1, PATCH_ELEMENTS, 8'h07, 1'b1);
        push_pixel(1, 31, 8'hFF, 1'b0);
        push_pixel(1, 0, 8'h80, 1'b1);
        // Same position twice.
        push_pixel(0, 0, 8'hFF, 1'b0);
        push_pixel(0, 0, 8'hFF, 1'b1);
        // Channel switch inside a patch.
        push_pixel(1, 2, 8'd100, 1'b0);
        push_pixel(0, 2, 8'd17, 1'b1);
        // Codebook rewrite in the middle of a patch.
        push_pixel(0, 3, 8'd200, 1'b0);
        push_write(12, 3, 12'd3200);
        push_pixel(0, 3, 8'd200, 1'b1);
        drain();

        // Drive every accumulator of channel 1 into saturation.
        for (ci = NUM_CODEWORDS; ci < TOTAL_CODES; ci++)
            push_write(ci, PATCH_ELEMENTS - 1, 12'hFFF);
        for (i = 0; i < SAT_PIXELS; i++)
            push_pixel(1, PATCH_ELEMENTS - 1, 8'h00, i == SAT_PIXELS - 1);
        drain();

        // Zero distance against a zero limit and against a limit of one.
        set_limit(32'h0000_0000);
        push_pixel(0, PATCH_ELEMENTS, 8'h00, 1'b1);
        drain();
        set_limit(32'h0000_0001);
        push_pixel(0, PATCH_ELEMENTS, 8'h00, 1'b1);
        drain();

        for (p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: lim = 32'hFFFF_FFFF;
                1, 7: lim = $urandom_range(6000);
                2: lim = 32'h0000_0000;
                3: lim = $urandom;
                4: lim = $urandom_range(20000, 1000);
                5: lim = 32'h0000_0001;
                default: lim = 32'hFFFF_FFFE;
            endcase
            set_limit(lim);
            apply_idle(idle_mode_t'(p % 4));
            queue_random_phase(RANDOM_ITEMS / NUM_PHASES);
            drain();
        end

        if (mismatches == 0 && apb_mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
